// ===== design/universal_integer_encoder_macros.svh =====
// Assertion helpers used by universal_integer_encoder.sv.
`ifndef UNIVERSAL_INTEGER_ENCODER_MACROS_SVH
`define UNIVERSAL_INTEGER_ENCODER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define UIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define UIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/uie_pkg.sv =====
`timescale 1ns / 1ps

package uie_pkg;

   localparam int UNARY_LIMIT_DEF = 2048;
   localparam int CHUNK_WIDTH_DEF = 32;
   localparam int MAX_RESULTS     = 64;

   // Longest gamma word is 2*32+1 bits.
   localparam int WORD_W    = 65;
   // Bit count of a word, up to the largest unary length.
   localparam int CNT_W     = 12;
   localparam int VALUE_W   = 32;
   localparam int BITS_W    = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_CODE_KIND    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINARY_WIDTH = 1'b1;

   localparam logic [BITS_W-1:0] BINARY_WIDTH_RST = 6'd8;

   typedef enum logic [1:0] {
      KIND_BINARY = 2'd0,
      KIND_UNARY  = 2'd1,
      KIND_GAMMA  = 2'd2,
      KIND_DELTA  = 2'd3
   } code_kind_type;

   // One code word handed to the chunk emitter, left aligned.
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [CNT_W-1:0]  rem;
      logic              uni;
      logic              too_long;
   } uie_item_type;

   // Number of significant bits, 0 for zero.
   function automatic logic [BITS_W-1:0] bit_len(input logic [VALUE_W-1:0] v);
      logic [BITS_W-1:0] r;
      r = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (v[i]) r = BITS_W'(i + 1);
      end
      return r;
   endfunction

   // Ones in the low n bits, n up to 32.
   function automatic logic [VALUE_W:0] low_mask(input logic [BITS_W-1:0] n);
      return ((VALUE_W+1)'(1) << n) - (VALUE_W+1)'(1);
   endfunction

endpackage

// ===== design/uie_emitter.sv =====
`timescale 1ns / 1ps

module uie_emitter
   import uie_pkg::*;
#(
   parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  uie_item_type        in_item,
   output logic                take,
   output logic                rsp_strobe,
   output logic [VALUE_W-1:0]  rsp_code_chunk,
   output logic [BITS_W-1:0]   rsp_chunk_bits,
   output logic                rsp_last_chunk,
   output logic                rsp_too_long
);

   localparam logic [CHUNK_WIDTH-1:0] ONES  = '1;
   localparam logic [CHUNK_WIDTH-1:0] TAIL  = ~CHUNK_WIDTH'(1);
   localparam logic [CNT_W-1:0]       CW    = CNT_W'(CHUNK_WIDTH);

   logic               em_valid_ff, em_valid_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               uni_ff, uni_in;
   logic               tl_ff, tl_in;

   logic               strobe_ff;
   logic [VALUE_W-1:0] code_ff, code_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic               last_ff;
   logic               tlo_ff;

   logic                   last;
   logic [CHUNK_WIDTH-1:0] top;
   logic [CNT_W-1:0]       sh;

   assign last = (rem_ff <= CW);
   assign take = !em_valid_ff || last;

   always_comb begin
      em_valid_in = em_valid_ff;
      word_in     = word_ff << CHUNK_WIDTH;
      rem_in      = rem_ff - CW;
      uni_in      = uni_ff;
      tl_in       = tl_ff;
      if (take) begin
         em_valid_in = in_valid;
         word_in     = in_item.word;
         rem_in      = in_item.rem;
         uni_in      = in_item.uni;
         tl_in       = in_item.too_long;
      end
   end

   // Unary chunks are ones, with a closing zero on the last one.
   always_comb begin
      sh = CW - rem_ff;
      if (uni_ff) begin
         top = last ? (TAIL << sh) : ONES;
      end else begin
         top = word_ff[WORD_W-1 -: CHUNK_WIDTH];
      end
      code_in = VALUE_W'(last ? (top >> sh) : top);
      bits_in = last ? BITS_W'(rem_ff) : BITS_W'(CHUNK_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         em_valid_ff <= em_valid_in;
         strobe_ff   <= em_valid_ff;
      end
      word_ff <= word_in;
      rem_ff  <= rem_in;
      uni_ff  <= uni_in;
      tl_ff   <= tl_in;
      code_ff <= code_in;
      bits_ff <= bits_in;
      last_ff <= last;
      tlo_ff  <= tl_ff;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_code_chunk = code_ff;
   assign rsp_chunk_bits = bits_ff;
   assign rsp_last_chunk = last_ff;
   assign rsp_too_long   = tlo_ff;

endmodule

// ===== design/universal_integer_encoder.sv =====
`timescale 1ns / 1ps

// Universal integer encoder: fixed binary, unary, gamma or delta code words.
// Input: raise start with req_value; the value is taken at an edge where busy
// is low. Output: each chunk of the code word, most significant bit first,
// is on the rsp_ ports for one cycle with rsp_strobe high; the receiver takes
// every chunk and cannot stall. rsp_last_chunk marks the end of a word, and a
// refused unary value gives a single empty chunk with rsp_too_long set.
// Configuration: write code_kind (index 0) and binary_width (index 1) through
// csr_we / csr_index / csr_wdata while no item is in flight.
// Path: an accepted item passes the three front stages and the chunk register,
// then each chunk goes out through the output register.
// Throughput: the chunk emitter sends one chunk per cycle; a code word has
// one chunk for binary, up to three for gamma and up to two for delta at
// 32-bit chunks, and up to 64 for unary. busy is high while the front stage
// is full and cannot advance behind the emitter.
// Reset: clears all stage valid bits and sets code_kind to gamma and
// binary_width to 8.
module universal_integer_encoder
   import uie_pkg::*;
#(
   parameter int UNARY_LIMIT = UNARY_LIMIT_DEF,
   parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 rsp_strobe,
   output logic [VALUE_W-1:0]   rsp_code_chunk,
   output logic [BITS_W-1:0]    rsp_chunk_bits,
   output logic                 rsp_last_chunk,
   output logic                 rsp_too_long,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

`include "universal_integer_encoder_macros.svh"

   localparam int ULIM = (UNARY_LIMIT < MAX_RESULTS * CHUNK_WIDTH) ?
                         UNARY_LIMIT : MAX_RESULTS * CHUNK_WIDTH;
   localparam logic [VALUE_W-1:0] ULIM_V = VALUE_W'(ULIM);

   code_kind_type     code_kind_ff;
   logic [BITS_W-1:0] binary_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_kind_ff    <= KIND_GAMMA;
         binary_width_ff <= BINARY_WIDTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CODE_KIND:    code_kind_ff    <= code_kind_type'(csr_wdata[1:0]);
            CSR_BINARY_WIDTH: binary_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: captured item.
   logic               s1_valid_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   code_kind_type      s1_kind_ff;
   logic [BITS_W-1:0]  s1_bw_ff;

   // Stage 2: lengths and unary refusal.
   logic               s2_valid_ff;
   logic [VALUE_W-1:0] s2_value_ff;
   code_kind_type      s2_kind_ff;
   logic [BITS_W-1:0]  s2_n_ff, s2_n_in;
   logic [BITS_W-1:0]  s2_l_ff, s2_l_in;
   logic [2:0]         s2_lm_ff, s2_lm_in;
   logic               s2_tl_ff, s2_tl_in;

   // Stage 3: right-aligned word and its length.
   logic               s3_valid_ff;
   logic [WORD_W-1:0]  s3_word_ff, s3_word_in;
   logic [CNT_W-1:0]   s3_len_ff, s3_len_in;
   logic               s3_uni_ff;
   logic               s3_tl_ff;

   logic         em_take;
   logic         s3_adv, s2_adv, accept;
   uie_item_type em_item;

   assign s3_adv = !s3_valid_ff || em_take;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign busy   = s1_valid_ff && !s2_adv;
   assign accept = start && !busy;

   always_comb begin
      logic [BITS_W-1:0] m;
      s2_n_in  = (s1_bw_ff > BITS_W'(VALUE_W)) ? BITS_W'(VALUE_W) : s1_bw_ff;
      s2_l_in  = bit_len(s1_value_ff);
      m        = s2_l_in + BITS_W'(1);
      s2_lm_in = 3'(bit_len(VALUE_W'(m)));
      s2_tl_in = (s1_kind_ff == KIND_UNARY) && (s1_value_ff > ULIM_V);
   end

   always_comb begin
      logic [BITS_W-1:0] m;
      logic [12:0]       prefix;
      logic [BITS_W:0]   l1;
      m      = s2_l_ff + BITS_W'(1);
      l1     = {1'b0, s2_l_ff} + (BITS_W+1)'(1);
      prefix = (13'(low_mask(BITS_W'(s2_lm_ff))) << (s2_lm_ff + 3'd1)) | 13'(m);
      s3_word_in = '0;
      s3_len_in  = '0;
      case (s2_kind_ff)
         KIND_BINARY: begin
            s3_word_in = WORD_W'(s2_value_ff & VALUE_W'(low_mask(s2_n_ff)));
            s3_len_in  = CNT_W'(s2_n_ff);
         end
         KIND_UNARY: begin
            // Values 0 and 1 both give a single zero.
            if (!s2_tl_ff) begin
               s3_len_in = (s2_value_ff == '0) ? CNT_W'(1) : CNT_W'(s2_value_ff);
            end
         end
         KIND_GAMMA: begin
            s3_word_in = (WORD_W'(low_mask(s2_l_ff)) << l1) | WORD_W'(s2_value_ff);
            s3_len_in  = CNT_W'({s2_l_ff, 1'b1});
         end
         default: begin
            s3_word_in = (WORD_W'(prefix) << s2_l_ff) | WORD_W'(s2_value_ff);
            s3_len_in  = CNT_W'({s2_lm_ff, 1'b1}) + CNT_W'(s2_l_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (!busy)  s1_valid_ff <= accept;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
      end
      if (accept) begin
         s1_value_ff <= req_value;
         s1_kind_ff  <= code_kind_ff;
         s1_bw_ff    <= binary_width_ff;
      end
      if (s2_adv) begin
         s2_value_ff <= s1_value_ff;
         s2_kind_ff  <= s1_kind_ff;
         s2_n_ff     <= s2_n_in;
         s2_l_ff     <= s2_l_in;
         s2_lm_ff    <= s2_lm_in;
         s2_tl_ff    <= s2_tl_in;
      end
      if (s3_adv) begin
         s3_word_ff <= s3_word_in;
         s3_len_ff  <= s3_len_in;
         s3_uni_ff  <= (s2_kind_ff == KIND_UNARY);
         s3_tl_ff   <= s2_tl_ff;
      end
   end

   // Left-align the word so the emitter always reads from the top.
   always_comb begin
      em_item.word     = s3_uni_ff ? '0 : (s3_word_ff << (CNT_W'(WORD_W) - s3_len_ff));
      em_item.rem      = s3_len_ff;
      em_item.uni      = s3_uni_ff;
      em_item.too_long = s3_tl_ff;
   end

   uie_emitter #(
      .CHUNK_WIDTH(CHUNK_WIDTH)
   ) u_emitter (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s3_valid_ff),
      .in_item        (em_item),
      .take           (em_take),
      .rsp_strobe     (rsp_strobe),
      .rsp_code_chunk (rsp_code_chunk),
      .rsp_chunk_bits (rsp_chunk_bits),
      .rsp_last_chunk (rsp_last_chunk),
      .rsp_too_long   (rsp_too_long)
   );

   `UIE_ASSERT_NEXT(a_chunks_back_to_back, clock, reset, rsp_strobe && !rsp_last_chunk, rsp_strobe, "code word broken between chunks")
   `UIE_ASSERT_NOW(a_full_mid_chunk, clock, reset, rsp_strobe && !rsp_last_chunk, rsp_chunk_bits == BITS_W'(CHUNK_WIDTH), "non-final chunk not full")
   `UIE_ASSERT_NOW(a_refusal_empty, clock, reset, rsp_strobe && rsp_too_long, rsp_last_chunk && (rsp_chunk_bits == '0) && (rsp_code_chunk == '0), "refused unary not a single empty chunk")
   `UIE_ASSERT_NEXT(a_accept_loads, clock, reset, accept, s1_valid_ff, "accepted item not captured")

endmodule
